FILE: rtl/fixed_slot_allocator_macros.svh
// assertion macros used by the slot allocator checker
`ifndef FIXED_SLOT_ALLOCATOR_MACROS_SVH
`define FIXED_SLOT_ALLOCATOR_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define FSA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fixed_slot_allocator: assertion failed");

// next-cycle implication, disabled while reset is held
`define FSA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fixed_slot_allocator: assertion failed");

`endif

FILE: rtl/fsa_pkg.sv
// types, codes and constants of the fixed slot allocator
package fsa_pkg;

    localparam int ADDR_W      = 32;
    localparam int LOG2_W      = 4;
    localparam int CNT_W       = 11;
    localparam int STATUS_W    = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int OUT_TDATA_W = 48;

    localparam int NUM_SLOTS_DEF = 1024;
    localparam int WORD_BITS_DEF = 64;

    localparam logic [ADDR_W-1:0] RST_REGION_BASE = 32'd0;
    localparam logic [LOG2_W-1:0] RST_SLOT_LOG2   = 4'd3;
    localparam logic [CNT_W-1:0]  RST_SLOTS       = 11'd1024;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 3'd0,
        ST_NO_SPACE     = 3'd1,
        ST_OUT_OF_RANGE = 3'd2,
        ST_MISALIGNED   = 3'd3,
        ST_ALREADY_FREE = 3'd4
    } t_status;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REGION_BASE  = 2'd0,
        CFG_SLOT_LOG2    = 2'd1,
        CFG_SLOTS_IN_USE = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        S_CLEAR  = 2'd0,
        S_IDLE   = 2'd1,
        S_READ   = 2'd2,
        S_UPDATE = 2'd3
    } t_state;

endpackage

FILE: rtl/fsa_word_ram.sv
// free-map word memory: one write port, one registered read port
module fsa_word_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/fixed_slot_allocator.sv
// Fixed slot allocator: hands out equal-size slots of a memory region, lowest address first,
// and takes them back. One free bit per slot is kept in a word memory of WORD_BITS-bit words
// with a summary bit per word in flip-flops. After acceptance a command reads its free-map
// word in S_READ, then in S_UPDATE waits until the output register is free, updates and
// writes back that word and registers its result. The next command is taken in the cycle
// after the result has gone to the output register, so a new command is taken only once
// the last one is through. After reset and after every write to a defined configuration
// register the free map is rebuilt by a clearing pass of one word per cycle over all
// NUM_WORDS words (16 at the defaults), during which no command is accepted.
module fixed_slot_allocator #(
    parameter int NUM_SLOTS = fsa_pkg::NUM_SLOTS_DEF,
    parameter int WORD_BITS = fsa_pkg::WORD_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [fsa_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [fsa_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [fsa_pkg::ADDR_W-1:0]         i_s_tdata,   // slot_address
    input  logic [0:0]                         i_s_tuser,   // command
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [fsa_pkg::OUT_TDATA_W-1:0]    o_m_tdata,   // granted_address, free_count, zero pad
    output logic [fsa_pkg::STATUS_W-1:0]       o_m_tuser    // status
);

    import fsa_pkg::*;

    localparam int NUM_WORDS = (NUM_SLOTS + WORD_BITS - 1) / WORD_BITS;
    localparam int WA_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int IDX_W     = $clog2(NUM_WORDS * WORD_BITS);
    localparam int PAD_W     = OUT_TDATA_W - CNT_W - ADDR_W;

    // configuration
    logic [ADDR_W-1:0]    r_region_base;
    logic [LOG2_W-1:0]    r_slot_log2;
    logic [CNT_W-1:0]     r_slots;
    logic                 cfg_hit;
    logic [CNT_W-1:0]     active_slots;

    // control
    t_state               r_state, n_state;
    logic [WA_W-1:0]      r_clr_addr, n_clr_addr;
    logic [NUM_WORDS-1:0] r_has_free, n_has_free;
    logic [CNT_W-1:0]     r_free_total, n_free_total;
    logic [WA_W-1:0]      r_first_word, first_word;
    logic                 r_any_free;

    // command in flight
    t_cmd                 r_cmd, n_cmd;
    logic [ADDR_W-1:0]    r_offset, n_offset;
    logic [WA_W-1:0]      r_word_addr, n_word_addr;
    logic [BIT_W-1:0]     r_bit, n_bit;
    t_status              r_chk, n_chk;

    // output register
    logic                 r_out_valid, n_out_valid;
    t_status              r_out_status, n_out_status;
    logic [ADDR_W-1:0]    r_out_granted, n_out_granted;
    logic [CNT_W-1:0]     r_out_count, n_out_count;

    // memory port
    logic                 ram_we, ram_re;
    logic [WA_W-1:0]      ram_waddr, ram_raddr;
    logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

    // datapath
    logic [WORD_BITS-1:0] clr_mask;
    logic [ADDR_W-1:0]    span;
    logic [ADDR_W-1:0]    align_mask;
    logic                 out_of_range;
    logic                 misaligned;
    logic [IDX_W-1:0]     slot_idx;
    logic [WA_W-1:0]      free_word;
    logic [BIT_W-1:0]     free_bit;
    logic [BIT_W-1:0]     pick_bit;
    logic [WORD_BITS-1:0] alloc_word;
    logic [ADDR_W-1:0]    grant_slot;
    logic [ADDR_W-1:0]    grant_addr;

    fsa_word_ram #(
        .DEPTH (NUM_WORDS),
        .WIDTH (WORD_BITS),
        .AW    (WA_W)
    ) u_word_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_cfg_ready = 1'b1;
    assign cfg_hit     = i_cfg_valid && (i_cfg_index == CFG_REGION_BASE ||
                                         i_cfg_index == CFG_SLOT_LOG2 ||
                                         i_cfg_index == CFG_SLOTS_IN_USE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region_base <= RST_REGION_BASE;
            r_slot_log2   <= RST_SLOT_LOG2;
            r_slots       <= RST_SLOTS;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_REGION_BASE:  r_region_base <= i_cfg_data[ADDR_W-1:0];
                CFG_SLOT_LOG2:    r_slot_log2   <= i_cfg_data[LOG2_W-1:0];
                CFG_SLOTS_IN_USE: r_slots       <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // slot count saturates at the map size
    always_comb begin
        if (32'(r_slots) > NUM_SLOTS) begin
            active_slots = CNT_W'(NUM_SLOTS);
        end else begin
            active_slots = r_slots;
        end
    end

    // rebuilt word for the clearing pass: bits of slots below the active count
    always_comb begin
        for (int b = 0; b < WORD_BITS; b++) begin
            clr_mask[b] = (32'(r_clr_addr) * WORD_BITS + b) < 32'(active_slots);
        end
    end

    // lowest word with a free slot, registered for the next command
    always_comb begin
        first_word = '0;
        for (int i = NUM_WORDS - 1; i >= 0; i--) begin
            if (r_has_free[i]) begin
                first_word = WA_W'(i);
            end
        end
    end

    // free path checks on the offset into the region
    assign span         = 32'(active_slots) << r_slot_log2;
    assign align_mask   = (32'd1 << r_slot_log2) - 32'd1;
    assign out_of_range = r_offset >= span;
    assign misaligned   = (r_offset & align_mask) != '0;
    assign slot_idx     = IDX_W'(r_offset >> r_slot_log2);
    assign free_word    = WA_W'(slot_idx / WORD_BITS);
    assign free_bit     = BIT_W'(slot_idx % WORD_BITS);

    // lowest free bit of the word read for an allocate
    always_comb begin
        pick_bit = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (ram_rdata[b]) begin
                pick_bit = BIT_W'(b);
            end
        end
    end

    assign alloc_word = ram_rdata & ~({{(WORD_BITS-1){1'b0}}, 1'b1} << pick_bit);
    assign grant_slot = 32'(r_word_addr) * WORD_BITS + 32'(pick_bit);
    assign grant_addr = r_region_base + (grant_slot << r_slot_log2);

    always_comb begin
        n_state       = r_state;
        n_clr_addr    = r_clr_addr;
        n_has_free    = r_has_free;
        n_free_total  = r_free_total;
        n_cmd         = r_cmd;
        n_offset      = r_offset;
        n_word_addr   = r_word_addr;
        n_bit         = r_bit;
        n_chk         = r_chk;
        n_out_valid   = r_out_valid && !i_m_tready;
        n_out_status  = r_out_status;
        n_out_granted = r_out_granted;
        n_out_count   = r_out_count;
        ram_we        = 1'b0;
        ram_waddr     = r_word_addr;
        ram_wdata     = ram_rdata;
        ram_re        = 1'b0;
        ram_raddr     = r_word_addr;

        case (r_state)
            S_CLEAR: begin
                ram_we                 = 1'b1;
                ram_waddr              = r_clr_addr;
                ram_wdata              = clr_mask;
                n_has_free[r_clr_addr] = |clr_mask;
                n_free_total           = active_slots;
                if (r_clr_addr == WA_W'(NUM_WORDS - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_cmd    = t_cmd'(i_s_tuser);
                    n_offset = i_s_tdata - r_region_base;
                    n_state  = S_READ;
                end
            end
            S_READ: begin
                if (r_cmd == CMD_ALLOC) begin
                    n_word_addr = r_first_word;
                    n_chk       = r_any_free ? ST_OK : ST_NO_SPACE;
                end else begin
                    n_word_addr = free_word;
                    n_bit       = free_bit;
                    if (out_of_range) begin
                        n_chk = ST_OUT_OF_RANGE;
                    end else if (misaligned) begin
                        n_chk = ST_MISALIGNED;
                    end else begin
                        n_chk = ST_OK;
                    end
                end
                ram_re    = 1'b1;
                ram_raddr = n_word_addr;
                n_state   = S_UPDATE;
            end
            S_UPDATE: begin
                // wait here until the output register is free
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid   = 1'b1;
                    n_out_status  = r_chk;
                    n_out_granted = '0;
                    if (r_chk == ST_OK) begin
                        if (r_cmd == CMD_ALLOC) begin
                            ram_we                  = 1'b1;
                            ram_wdata               = alloc_word;
                            n_has_free[r_word_addr] = |alloc_word;
                            n_free_total            = r_free_total - 1'b1;
                            n_out_granted           = grant_addr;
                        end else if (ram_rdata[r_bit]) begin
                            n_out_status = ST_ALREADY_FREE;
                        end else begin
                            ram_we    = 1'b1;
                            ram_wdata = ram_rdata |
                                        ({{(WORD_BITS-1){1'b0}}, 1'b1} << r_bit);
                            n_has_free[r_word_addr] = 1'b1;
                            n_free_total            = r_free_total + 1'b1;
                        end
                    end
                    n_out_count = n_free_total;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase

        // any write to a defined register rebuilds the map
        if (cfg_hit) begin
            n_state    = S_CLEAR;
            n_clr_addr = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_addr   <= '0;
            r_has_free   <= '0;
            r_free_total <= '0;
            r_any_free   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr_addr   <= n_clr_addr;
            r_has_free   <= n_has_free;
            r_free_total <= n_free_total;
            r_any_free   <= |r_has_free;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_first_word  <= first_word;
        r_cmd         <= n_cmd;
        r_offset      <= n_offset;
        r_word_addr   <= n_word_addr;
        r_bit         <= n_bit;
        r_chk         <= n_chk;
        r_out_status  <= n_out_status;
        r_out_granted <= n_out_granted;
        r_out_count   <= n_out_count;
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{PAD_W{1'b0}}, r_out_count, r_out_granted};
    assign o_m_tuser  = r_out_status;

endmodule

FILE: rtl/fsa_checker.sv
// port-level checks of the fixed slot allocator, bound to the top level
`include "fixed_slot_allocator_macros.svh"

module fsa_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_tvalid,
    input logic                            o_s_tready,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [fsa_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    input logic [fsa_pkg::STATUS_W-1:0]    o_m_tuser
);

    import fsa_pkg::*;

    // one command at a time: no second word right after an accepted one
    `FSA_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_s_tvalid && o_s_tready, !o_s_tready)

    // only a successful allocate carries an address; the check covers results with a failed status
    `FSA_ASSERT_IMPL(a_grant_zero, i_clk, i_rst_n, o_m_tvalid && (o_m_tuser != ST_OK || o_m_tdata[ADDR_W +: CNT_W] == '0) && o_m_tuser != ST_OK, o_m_tdata[ADDR_W-1:0] == '0)

    // no space only when the free count is zero
    `FSA_ASSERT_IMPL(a_no_space_empty, i_clk, i_rst_n, o_m_tvalid && (o_m_tuser == ST_NO_SPACE), o_m_tdata[ADDR_W +: CNT_W] == '0)

    `FSA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))

endmodule

bind fixed_slot_allocator fsa_checker u_fsa_checker (.*);
